FILE: rtl/core/tcchs_pkg.sv
// shared constants and types of the track cached chs sector reader
package tcchs_pkg;

  localparam int unsigned CacheDepth = 18;
  localparam int unsigned DivW       = 32;
  localparam int unsigned RemW       = 11;
  localparam int unsigned CntW       = $clog2(DivW);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 11;

  localparam logic [CfgIdxW-1:0] CFG_SECTORS_PER_TRACK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEAD_COUNT        = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CYLINDER_COUNT    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DRIVE_SELECT      = 2'd3;

  typedef struct packed {
    logic [DivW-1:0] quotient;
    logic [RemW-1:0] remainder;
  } div_res_t;

endpackage

FILE: rtl/core/tcchs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module tcchs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tcchs_pkg::DivW-1:0] dividend_i,
  input  logic [tcchs_pkg::RemW-1:0] divisor_i,
  output logic                       done_o,
  output tcchs_pkg::div_res_t        res_o
);
  import tcchs_pkg::*;

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q;
  logic [RemW-1:0] rem_q;
  logic [RemW-1:0] div_q;

  logic [RemW:0]   rem_shift;
  logic [RemW:0]   rem_diff;
  logic            q_bit;

  assign rem_shift = {rem_q, quo_q[DivW-1]};
  assign rem_diff  = rem_shift - {1'b0, div_q};
  assign q_bit     = (rem_shift >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q + 1'b1;
        busy_q <= (cnt_q != CntW'(DivW - 1));
        done_q <= (cnt_q == CntW'(DivW - 1));
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], q_bit};
      rem_q <= q_bit ? rem_diff[RemW-1:0] : rem_shift[RemW-1:0];
    end
  end

  assign done_o         = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

FILE: rtl/core/track_cached_chs_sector_reader.sv
// top level: sector counter, track cache range and chs conversion sequencer
// a hit goes from the check state to the done state and the output registers; a miss
// also runs the division states; one item at a time, the input stalled outside idle;
// a miss runs three 32-step divisions in a single bit-serial divider
// a request of 0 is taken while idle and gives no result, even with a stalled result
// reset (async, active low) restores the default geometry and empties the cache
module track_cached_chs_sector_reader (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcchs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcchs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_request_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           out_hit_o,
  output logic [4:0]                     out_cache_slot_o,
  output logic [15:0]                    out_volume_o,
  output logic                           out_volume_change_o,
  output logic [9:0]                     out_cylinder_o,
  output logic [7:0]                     out_head_o,
  output logic [5:0]                     out_sector_o,
  output logic [4:0]                     out_sector_count_o
);
  import tcchs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_SEC,
    ST_DIV_HEAD,
    ST_DIV_CYL,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [5:0]  spt_q;
  logic [8:0]  heads_q;
  logic [10:0] cyls_q;

  // sequencer state
  logic [31:0] next_q;
  logic [31:0] first_q;
  logic [31:0] end_q;
  logic        cvalid_q;
  logic [15:0] cur_vol_q;

  logic [31:0] offset_q;
  logic [31:0] span_q;
  logic        hit_q;
  logic [5:0]  s_q;
  logic [7:0]  h_q;
  logic [9:0]  c_q;
  logic [15:0] vol_q;

  logic            div_start_q;
  logic [DivW-1:0] div_a_q;
  logic [RemW-1:0] div_b_q;
  logic            div_done;
  div_res_t        div_res;

  // output registers
  logic        out_valid_q;
  logic        o_hit_q;
  logic [4:0]  o_slot_q;
  logic [15:0] o_vol_q;
  logic        o_chg_q;
  logic [9:0]  o_cyl_q;
  logic [7:0]  o_head_q;
  logic [5:0]  o_sec_q;
  logic [4:0]  o_cnt_q;

  logic [5:0]  spt_eff;
  logic [8:0]  heads_eff;
  logic [10:0] cyls_eff;
  logic [5:0]  sc_full;
  logic [4:0]  sc;
  logic        out_free;
  logic        cache_hit;
  logic        div_kick;

  assign spt_eff   = (spt_q == '0) ? 6'd1 : spt_q;
  assign heads_eff = (heads_q == '0) ? 9'd1 : heads_q;
  assign cyls_eff  = (cyls_q == '0) ? 11'd1 : cyls_q;
  assign sc_full   = spt_eff - s_q;
  assign sc        = (sc_full > 6'(CacheDepth)) ? 5'(CacheDepth) : sc_full[4:0];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign cache_hit = cvalid_q && (offset_q < span_q);
  assign div_kick  = ((state_q == ST_CHECK) && !cache_hit) ||
                     (((state_q == ST_DIV_SEC) || (state_q == ST_DIV_HEAD)) && div_done);

  tcchs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q   <= 6'd18;
      heads_q <= 9'd2;
      cyls_q  <= 11'd80;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SECTORS_PER_TRACK: spt_q   <= cfg_data_i[5:0];
        CFG_HEAD_COUNT:        heads_q <= cfg_data_i[8:0];
        CFG_CYLINDER_COUNT:    cyls_q  <= cfg_data_i;
        // drive select changes no result field
        CFG_DRIVE_SELECT:      ;
        default:               ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_q      <= '0;
      first_q     <= '0;
      end_q       <= '0;
      cvalid_q    <= 1'b0;
      cur_vol_q   <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= div_kick;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_request_i) begin
            offset_q <= next_q - first_q;
            span_q   <= end_q - first_q;
            state_q  <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          hit_q <= cache_hit;
          if (cache_hit) begin
            state_q <= ST_DONE;
          end else begin
            div_a_q <= next_q;
            div_b_q <= RemW'(spt_eff);
            state_q <= ST_DIV_SEC;
          end
        end
        ST_DIV_SEC: begin
          if (div_done) begin
            s_q     <= div_res.remainder[5:0];
            div_a_q <= div_res.quotient;
            div_b_q <= RemW'(heads_eff);
            state_q <= ST_DIV_HEAD;
          end
        end
        ST_DIV_HEAD: begin
          if (div_done) begin
            h_q     <= div_res.remainder[7:0];
            div_a_q <= div_res.quotient;
            div_b_q <= cyls_eff;
            state_q <= ST_DIV_CYL;
          end
        end
        ST_DIV_CYL: begin
          if (div_done) begin
            c_q     <= div_res.remainder[9:0];
            // volume saturates at the top of its 16-bit range
            vol_q   <= (div_res.quotient[31:16] != '0) ? 16'hFFFF
                                                       : div_res.quotient[15:0];
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            next_q <= next_q + 32'd1;
            if (hit_q) begin
              o_hit_q  <= 1'b1;
              o_slot_q <= offset_q[4:0];
              o_vol_q  <= cur_vol_q;
              o_chg_q  <= 1'b0;
              o_cyl_q  <= '0;
              o_head_q <= '0;
              o_sec_q  <= '0;
              o_cnt_q  <= '0;
            end else begin
              o_hit_q   <= 1'b0;
              o_slot_q  <= '0;
              o_vol_q   <= vol_q;
              o_chg_q   <= (vol_q != cur_vol_q);
              o_cyl_q   <= c_q;
              o_head_q  <= h_q;
              o_sec_q   <= s_q + 6'd1;
              o_cnt_q   <= sc;
              cur_vol_q <= vol_q;
              first_q   <= next_q;
              end_q     <= next_q + {27'd0, sc};
              cvalid_q  <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign out_hit_o           = o_hit_q;
  assign out_cache_slot_o    = o_slot_q;
  assign out_volume_o        = o_vol_q;
  assign out_volume_change_o = o_chg_q;
  assign out_cylinder_o      = o_cyl_q;
  assign out_head_o          = o_head_q;
  assign out_sector_o        = o_sec_q;
  assign out_sector_count_o  = o_cnt_q;

endmodule
